>>> hdl/tipf_pkg.sv
// Shared constants and helpers for the touch/impact pat fusion block.
// No dependencies; used by touch_impact_pat_fusion_top and tipf_checker.
package tipf_pkg;

  // Default width of the stored millisecond timestamps.
  localparam int unsigned TimeWidthDef = 32;

  // Port widths fixed by the item formats.
  localparam int unsigned LineW    = 8;
  localparam int unsigned PoseW    = 8;
  localparam int unsigned StampW   = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned PartW    = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotW    = 2;
  localparam int unsigned CntW     = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHeadLine     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegChinLine     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLeftEarLine  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRightEarLine = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDebounce     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPatWindow    = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [MsW-1:0] DebounceRst  = 16'd100;
  localparam logic [MsW-1:0] PatWindowRst = 16'd200;

  // Slot numbers in priority order.
  localparam logic [SlotW-1:0] SlotHead = 2'd0;
  localparam logic [SlotW-1:0] SlotChin = 2'd1;
  localparam logic [SlotW-1:0] SlotLeft = 2'd2;
  localparam logic [SlotW-1:0] SlotRight = 2'd3;

  // Body part codes.
  localparam logic [PartW-1:0] PartHead     = 3'd0;
  localparam logic [PartW-1:0] PartChin     = 3'd2;
  localparam logic [PartW-1:0] PartLeftEar  = 3'd3;
  localparam logic [PartW-1:0] PartRightEar = 3'd4;

  // Touch kinds.
  localparam logic [KindW-1:0] KindPat   = 2'd1;
  localparam logic [KindW-1:0] KindTouch = 2'd3;

  // Pose codes that mean an impact.
  localparam logic [PoseW-1:0] PoseImpactA = 8'd1;
  localparam logic [PoseW-1:0] PoseImpactB = 8'd5;

  // Input function codes.
  localparam logic FuncTouch = 1'b0;
  localparam logic FuncPose  = 1'b1;

  // Body part of a slot.
  function automatic logic [PartW-1:0] slot_part(input logic [SlotW-1:0] slot);
    logic [PartW-1:0] part;
    unique case (slot)
      SlotHead: part = PartHead;
      SlotChin: part = PartChin;
      SlotLeft: part = PartLeftEar;
      default:  part = PartRightEar;
    endcase
    return part;
  endfunction

  // Part of an impact pat result, from the count of results still to send:
  // head first, then left ear, then right ear.
  function automatic logic [PartW-1:0] pat_part(input logic [CntW-1:0] remaining);
    logic [PartW-1:0] part;
    unique case (remaining)
      2'd3:    part = PartHead;
      2'd2:    part = PartLeftEar;
      default: part = PartRightEar;
    endcase
    return part;
  endfunction

endpackage

>>> hdl/touch_impact_pat_fusion_top.sv
// Top level of the touch/impact pat fusion block: input register, fusion
// logic with its stored times, and a result register. Depends on tipf_pkg.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid_i / in_ready_o | func_i line_number_i rising_edge_i pose_i
//           |                        | timestamp_ms_i
//  result   | out_valid_o/out_ready_i | part_o touch_kind_o pressed_flag_o
//           |                        | last_of_run_o
//  config   | cfg_we_i               | cfg_idx_i cfg_wdata_i
//
// A request is captured in the input register and resolved once the result
// register is free, when the stored times are updated and its results land in
// the result register, from which the first result is offered on the result port.
// A touch edge or an impact without a pat gives at most one result and the
// block then takes one request per cycle while out_ready_i stays high; an
// impact pat gives three results, which the single result register sends one
// per cycle while out_ready_i is high, so such a request holds the result port
// until all three have left.
// A stall on the result side holds the result register; the input register
// still takes one more request, and only then does in_ready_o drop.
// Reset (rst_ni low, asynchronous) empties both registers, clears all stored
// times and press flags and loads the configuration defaults.
module touch_impact_pat_fusion_top #(
  parameter int unsigned TimeWidth = tipf_pkg::TimeWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [tipf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tipf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input requests.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [tipf_pkg::LineW-1:0]     line_number_i,
  input  logic                           rising_edge_i,
  input  logic [tipf_pkg::PoseW-1:0]     pose_i,
  input  logic [tipf_pkg::StampW-1:0]    timestamp_ms_i,
  // Results.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tipf_pkg::PartW-1:0]     part_o,
  output logic [tipf_pkg::KindW-1:0]     touch_kind_o,
  output logic                           pressed_flag_o,
  output logic                           last_of_run_o
);

  // True when a - b, read as a signed time difference, is at most lim
  // (below lim when strict). A negative difference always counts as within.
  function automatic logic gap_within(input logic [TimeWidth-1:0] a,
                                      input logic [TimeWidth-1:0] b,
                                      input logic [tipf_pkg::MsW-1:0] lim,
                                      input logic strict);
    logic [TimeWidth-1:0] diff;
    logic [TimeWidth-1:0] lim_ext;
    diff    = a - b;
    lim_ext = TimeWidth'(lim);
    return diff[TimeWidth-1] | (strict ? (diff < lim_ext) : (diff <= lim_ext));
  endfunction

  // Configuration registers.
  logic [tipf_pkg::LineW-1:0] cfg_line_q [tipf_pkg::NumSlots];
  logic [tipf_pkg::MsW-1:0]   debounce_q;
  logic [tipf_pkg::MsW-1:0]   pat_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_line_q[0] <= tipf_pkg::LineW'(tipf_pkg::SlotHead);
      cfg_line_q[1] <= tipf_pkg::LineW'(tipf_pkg::SlotChin);
      cfg_line_q[2] <= tipf_pkg::LineW'(tipf_pkg::SlotLeft);
      cfg_line_q[3] <= tipf_pkg::LineW'(tipf_pkg::SlotRight);
      debounce_q    <= tipf_pkg::DebounceRst;
      pat_window_q  <= tipf_pkg::PatWindowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tipf_pkg::RegHeadLine:     cfg_line_q[0] <= cfg_wdata_i[tipf_pkg::LineW-1:0];
        tipf_pkg::RegChinLine:     cfg_line_q[1] <= cfg_wdata_i[tipf_pkg::LineW-1:0];
        tipf_pkg::RegLeftEarLine:  cfg_line_q[2] <= cfg_wdata_i[tipf_pkg::LineW-1:0];
        tipf_pkg::RegRightEarLine: cfg_line_q[3] <= cfg_wdata_i[tipf_pkg::LineW-1:0];
        tipf_pkg::RegDebounce:     debounce_q    <= cfg_wdata_i;
        tipf_pkg::RegPatWindow:    pat_window_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                          in_valid_q;
  logic                          func_q;
  logic [tipf_pkg::LineW-1:0]    line_q;
  logic                          rising_q;
  logic [tipf_pkg::PoseW-1:0]    pose_q;
  logic [tipf_pkg::StampW-1:0]   stamp_q;

  // Result register: a count of results still to send, and either one
  // touch result or the fixed impact pat triple.
  logic [tipf_pkg::CntW-1:0]     out_cnt_q, out_cnt_d;
  logic                          out_trip_q, out_trip_d;
  logic [tipf_pkg::PartW-1:0]    out_part_q, out_part_d;
  logic [tipf_pkg::KindW-1:0]    out_kind_q, out_kind_d;
  logic                          out_pressed_q, out_pressed_d;

  // Fusion state.
  logic [TimeWidth-1:0]          press_time_q [tipf_pkg::NumSlots];
  logic [tipf_pkg::NumSlots-1:0] press_seen_q;
  logic [TimeWidth-1:0]          impact_time_q, impact_time_d;
  logic [TimeWidth-1:0]          pat_press_q, pat_press_d;

  logic out_free;
  logic proc_fire;
  logic in_fire;
  logic out_fire;

  assign out_fire   = out_valid_o & out_ready_i;
  // The result register can take new results when empty or when its last
  // result leaves in this cycle.
  assign out_free   = (out_cnt_q == '0) | ((out_cnt_q == 2'd1) & out_ready_i);
  assign proc_fire  = in_valid_q & out_free;
  assign in_ready_o = ~in_valid_q | proc_fire;
  assign in_fire    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= func_i;
      line_q   <= line_number_i;
      rising_q <= rising_edge_i;
      pose_q   <= pose_i;
      stamp_q  <= timestamp_ms_i;
    end
  end

  // Fusion logic on the registered request.
  logic                       slot_hit;
  logic [tipf_pkg::SlotW-1:0] slot;
  logic [TimeWidth-1:0]       now;
  logic                       is_press;
  logic                       is_impact;
  logic                       debounced;
  logic                       touch_pat;
  logic                       impact_pat;
  logic                       emit_one;
  logic                       store_press;

  always_comb begin
    slot_hit = 1'b0;
    slot     = tipf_pkg::SlotHead;
    // Scan from the last slot down so that the first match wins.
    for (int i = tipf_pkg::NumSlots - 1; i >= 0; i--) begin
      if (cfg_line_q[i] == line_q) begin
        slot_hit = 1'b1;
        slot     = tipf_pkg::SlotW'(i);
      end
    end
  end

  always_comb begin
    now       = TimeWidth'(stamp_q);
    is_press  = ~rising_q;
    is_impact = (pose_q == tipf_pkg::PoseImpactA) | (pose_q == tipf_pkg::PoseImpactB);

    debounced = press_seen_q[slot] &
                gap_within(now, press_time_q[slot], debounce_q, 1'b1);
    touch_pat = (impact_time_q != '0) &
                gap_within(now, impact_time_q, pat_window_q, 1'b0);
    impact_pat = (pat_press_q != '0) &
                 gap_within(now, pat_press_q, pat_window_q, 1'b0);

    impact_time_d = impact_time_q;
    pat_press_d   = pat_press_q;
    store_press   = 1'b0;
    emit_one      = 1'b0;
    out_part_d    = tipf_pkg::slot_part(slot);
    out_kind_d    = tipf_pkg::KindTouch;
    out_pressed_d = is_press;
    out_trip_d    = 1'b0;

    if (func_q == tipf_pkg::FuncPose) begin
      if (is_impact) begin
        if (impact_pat) begin
          // The impact completes a pat: both stored times are used up.
          impact_time_d = '0;
          pat_press_d   = '0;
          out_trip_d    = 1'b1;
        end else begin
          impact_time_d = now;
        end
      end
    end else if (slot_hit) begin
      if (!is_press) begin
        emit_one = 1'b1;
      end else if (!debounced) begin
        emit_one    = 1'b1;
        store_press = 1'b1;
        // The chin never takes part in a pat.
        if (slot != tipf_pkg::SlotChin) begin
          pat_press_d = now;
          if (touch_pat) begin
            out_kind_d    = tipf_pkg::KindPat;
            impact_time_d = '0;
          end
        end
      end
    end

    if (out_trip_d) begin
      out_cnt_d = 2'd3;
    end else if (emit_one) begin
      out_cnt_d = 2'd1;
    end else begin
      out_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tipf_pkg::NumSlots; i++) begin
        press_time_q[i] <= '0;
      end
      press_seen_q  <= '0;
      impact_time_q <= '0;
      pat_press_q   <= '0;
    end else if (proc_fire) begin
      impact_time_q <= impact_time_d;
      pat_press_q   <= pat_press_d;
      if (store_press) begin
        press_time_q[slot] <= now;
        press_seen_q[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (proc_fire) begin
      out_cnt_q <= out_cnt_d;
    end else if (out_fire) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_trip_q    <= out_trip_d;
      out_part_q    <= out_part_d;
      out_kind_q    <= out_kind_d;
      out_pressed_q <= out_pressed_d;
    end
  end

  // An impact pat always reads as a pressed pat on the part picked by the
  // remaining count; a touch result is sent as stored.
  assign out_valid_o    = out_cnt_q != '0;
  assign part_o         = out_trip_q ? tipf_pkg::pat_part(out_cnt_q) : out_part_q;
  assign touch_kind_o   = out_trip_q ? tipf_pkg::KindPat : out_kind_q;
  assign pressed_flag_o = out_trip_q | out_pressed_q;
  assign last_of_run_o  = out_cnt_q == 2'd1;

endmodule

>>> hdl/tipf_checker.sv
// Port-level checks for the touch/impact pat fusion block and the bind that
// attaches them to touch_impact_pat_fusion_top. Depends on tipf_pkg.
module tipf_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [tipf_pkg::PartW-1:0]    part_o,
  input logic [tipf_pkg::KindW-1:0]    touch_kind_o,
  input logic                          pressed_flag_o,
  input logic                          last_of_run_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(part_o) && $stable(touch_kind_o) &&
       $stable(pressed_flag_o) && $stable(last_of_run_o)))
    else $error("result changed while stalled");

  // Only the impact pat triple has results that are not the last of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |->
      (touch_kind_o == tipf_pkg::KindPat && pressed_flag_o &&
       (part_o == tipf_pkg::PartHead || part_o == tipf_pkg::PartLeftEar)))
    else $error("non-final result outside a pat triple");

  // Head pat of a triple is followed at once by the left ear pat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_run_o && part_o == tipf_pkg::PartHead) |=>
      (out_valid_o && !last_of_run_o && part_o == tipf_pkg::PartLeftEar &&
       touch_kind_o == tipf_pkg::KindPat))
    else $error("pat triple broken after head");

  // Left ear pat of a triple is followed at once by the final right ear pat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_run_o && part_o == tipf_pkg::PartLeftEar) |=>
      (out_valid_o && last_of_run_o && part_o == tipf_pkg::PartRightEar &&
       touch_kind_o == tipf_pkg::KindPat))
    else $error("pat triple broken after left ear");

  // A release is never a pat, and the chin never pats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (!pressed_flag_o || part_o == tipf_pkg::PartChin)) |->
      (touch_kind_o == tipf_pkg::KindTouch))
    else $error("pat reported on a release or on the chin");

endmodule

bind touch_impact_pat_fusion_top tipf_port_checker u_tipf_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .part_o         (part_o),
  .touch_kind_o   (touch_kind_o),
  .pressed_flag_o (pressed_flag_o),
  .last_of_run_o  (last_of_run_o)
);
